// File: rtl/generational_slot_map_defines.svh
// Assertion macros shared by the slot map RTL.
// Each macro takes a label, a trigger condition and an expected condition.
// The module that uses them must have signals named clk and rst.
`ifndef GENERATIONAL_SLOT_MAP_DEFINES_SVH
`define GENERATIONAL_SLOT_MAP_DEFINES_SVH

// The expected condition holds in the same cycle as the trigger.
`define GSM_ASSERT_SAME(label, trig, expect_c) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expect_c)) \
    else $error("%m: same-cycle check failed");

// The expected condition holds in the cycle after the trigger.
`define GSM_ASSERT_NEXT(label, trig, expect_c) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expect_c)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/gsm_pkg.sv
`default_nettype none

package gsm_pkg;

  // Fixed field widths of the handle and result words.
  localparam int OP_W     = 2;
  localparam int IDX_W    = 10;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried in the opcode field.
  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_DESTROY = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } seq_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic ready;  // a new transaction may be taken
    logic pop;    // freed-stack read data is valid this cycle
    logic fire;   // table data is valid and the result is committed
  } seq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/gsm_ram.sv
`default_nettype none

module gsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsm_seq.sv
`default_nettype none

module gsm_seq (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    pop_req,
  input  wire logic    out_busy,
  output gsm_pkg::seq_ctrl_t ctrl
);

  import gsm_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a create that reuses a freed slot passes through S_POP to
  // fetch the slot number before the table can be read.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = pop_req ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state; fire also needs the output free.
  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: ctrl.ready = 1'b1;
      S_POP:  ctrl.pop   = 1'b1;
      S_EXEC: ctrl.fire  = !out_busy;
      default: ctrl = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/generational_slot_map.sv
// Channel | Direction | Payload (lowest bit first)
// s_*     | in        | opcode[1:0], slot_index[11:2], generation[43:12]
// m_*     | out       | status[1:0], out_index[11:2], out_generation[43:12]
//
// Lookup, destroy and fresh create: the execute state reads the slot table and
// registers the result. Create of a freed slot first passes the pop state to
// read the stack before the slot table. A new transaction is taken only in idle.
// s_tready is low during reset, which clears only the counters, sequencer and
// output valid; slots at or above the fresh count read as generation zero and
// not live, so there is no clearing pass. A waiting result stalls execution.
`default_nettype none

`include "generational_slot_map_defines.svh"

module generational_slot_map #(
  parameter int SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // opcode, slot_index, generation, zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata   // status, out_index, out_generation, zero pad
);

  import gsm_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (SW > IDX_W) ? SW : IDX_W;
  localparam int TW = GEN_W + 1;

  // Input fields.
  op_t              op_in;
  logic [IDX_W-1:0] idx_in;
  logic [GEN_W-1:0] gen_in;
  logic [XW-1:0]    idx_in_ext;
  logic [SW-1:0]    slot_in;

  assign op_in      = op_t'(s_tdata[1:0]);
  assign idx_in     = s_tdata[11:2];
  assign gen_in     = s_tdata[43:12];
  assign idx_in_ext = XW'(idx_in);
  assign slot_in    = idx_in_ext[SW-1:0];

  // Allocation counters.
  logic [CW-1:0] stack_count;
  logic [CW-1:0] stack_count_next;
  logic [CW-1:0] fresh_count;
  logic [CW-1:0] fresh_count_next;
  logic [CW-1:0] stack_dec;
  logic          stack_nonempty;
  logic          pop_req;

  assign stack_dec      = stack_count - 1'b1;
  assign stack_nonempty = (stack_count != '0);
  assign pop_req        = (op_in == OP_CREATE) && stack_nonempty;

  // Sequencer.
  seq_ctrl_t ctrl;
  logic      accept;

  gsm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .pop_req  (pop_req),
    .out_busy (m_tvalid && !m_tready),
    .ctrl     (ctrl)
  );

  // No transaction is taken while reset is held.
  assign s_tready = ctrl.ready && !rst;
  assign accept   = s_tvalid && s_tready;

  // Held copy of the transaction being worked on.
  op_t              op_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_q;
  logic [SW-1:0]    slot_q;
  logic             from_stack;

  // Memories: slot table holds {live, generation}; freed stack holds slots.
  logic          tbl_we;
  logic [SW-1:0] tbl_waddr;
  logic [TW-1:0] tbl_wdata;
  logic          tbl_re;
  logic [SW-1:0] tbl_raddr;
  logic [TW-1:0] tbl_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_waddr;
  logic          stk_re;
  logic [SW-1:0] stk_rdata;

  assign tbl_re    = (accept && !pop_req) || ctrl.pop;
  assign tbl_raddr = ctrl.pop ? stk_rdata : slot_in;
  assign stk_re    = accept && pop_req;

  gsm_ram #(
    .WIDTH (TW),
    .DEPTH (SLOTS)
  ) u_slot_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  gsm_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_freed_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (slot_q),
    .rd_en   (stk_re),
    .rd_addr (stack_dec[SW-1:0]),
    .rd_data (stk_rdata)
  );

  // Capture the transaction; a pop replaces the slot with the stack top.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op_in;
      idx_q      <= idx_in;
      gen_q      <= gen_in;
      slot_q     <= slot_in;
      from_stack <= pop_req;
    end else if (ctrl.pop) begin
      slot_q <= stk_rdata;
    end
  end

  // Stored entry; slots never handed out read as not live, generation zero.
  logic             entry_used;
  logic             stored_live;
  logic [GEN_W-1:0] stored_gen;
  logic             idx_ok;
  logic             handle_ok;
  logic [SW-1:0]    fresh_slot;
  logic [XW-1:0]    slot_q_ext;
  logic [XW-1:0]    fresh_ext;

  assign entry_used  = CW'(slot_q) < fresh_count;
  assign stored_live = entry_used && tbl_rdata[GEN_W];
  assign stored_gen  = entry_used ? tbl_rdata[GEN_W-1:0] : '0;
  assign idx_ok      = 32'(idx_q) < 32'(SLOTS);
  assign handle_ok   = idx_ok && stored_live && (stored_gen == gen_q);
  assign fresh_slot  = fresh_count[SW-1:0];
  assign slot_q_ext  = XW'(slot_q);
  assign fresh_ext   = XW'(fresh_slot);

  // Result and state update for the transaction in its final cycle.
  status_t          res_status;
  logic [IDX_W-1:0] res_idx;
  logic [GEN_W-1:0] res_gen;

  always_comb begin
    res_status       = ST_BAD;
    res_idx          = '0;
    res_gen          = '0;
    tbl_we           = 1'b0;
    tbl_waddr        = slot_q;
    tbl_wdata        = '0;
    stk_we           = 1'b0;
    stk_waddr        = stack_count[SW-1:0];
    stack_count_next = stack_count;
    fresh_count_next = fresh_count;
    unique case (op_q)
      OP_CREATE: begin
        if (from_stack) begin
          res_status       = ST_OK;
          res_idx          = slot_q_ext[IDX_W-1:0];
          res_gen          = stored_gen;
          tbl_we           = ctrl.fire;
          tbl_wdata        = {1'b1, stored_gen};
          stack_count_next = stack_dec;
        end else if (fresh_count < CW'(SLOTS)) begin
          res_status       = ST_OK;
          res_idx          = fresh_ext[IDX_W-1:0];
          tbl_we           = ctrl.fire;
          tbl_waddr        = fresh_slot;
          tbl_wdata        = {1'b1, {GEN_W{1'b0}}};
          fresh_count_next = fresh_count + 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP, OP_DESTROY: begin
        res_idx = idx_q;
        if (idx_ok) begin
          res_gen = stored_gen;
        end
        if (handle_ok) begin
          res_status = ST_OK;
          if (op_q == OP_DESTROY) begin
            res_gen   = stored_gen + 1'b1;
            tbl_we    = ctrl.fire;
            tbl_wdata = {1'b0, res_gen};
            // A push onto a full stack is dropped.
            if (stack_count < CW'(SLOTS)) begin
              stk_we           = ctrl.fire;
              stack_count_next = stack_count + 1'b1;
            end
          end
        end
      end
      OP_UNUSED: begin
        res_status = ST_BAD;
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

  // Counters advance only when the result is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      fresh_count <= '0;
    end else if (ctrl.fire) begin
      stack_count <= stack_count_next;
      fresh_count <= fresh_count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      m_tdata <= {4'b0000, res_gen, res_idx, res_status};
    end
  end

  // The freed stack never holds more entries than there are slots.
  `GSM_ASSERT_SAME(a_stack_bound, 1'b1, stack_count <= CW'(SLOTS))
  // Fresh slots are never handed out beyond the capacity.
  `GSM_ASSERT_SAME(a_fresh_bound, 1'b1, fresh_count <= CW'(SLOTS))
  // A committed result never overwrites one still waiting at the output.
  `GSM_ASSERT_SAME(a_no_overwrite, ctrl.fire, !m_tvalid || m_tready)
  // Reusing a freed slot removes exactly one entry from the stack.
  `GSM_ASSERT_NEXT(a_pop_dec, ctrl.fire && (op_q == OP_CREATE) && from_stack,
                   stack_count == $past(stack_dec))

endmodule

`default_nettype wire

// File: sim/slot_map_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the slot map, predicts each result from its
// own copy of the slot table and compares every returned transaction with it.
module slot_map_checker
  import gsm_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   index;
    logic [GEN_W-1:0]   gen;
  } slot_result_t;

  // Shadow copy of the allocator state.
  logic [GEN_W-1:0] slot_gen   [SLOTS];
  logic             slot_live  [SLOTS];
  logic [IDX_W-1:0] freed_slots[SLOTS];
  int               freed_depth;
  int               fresh_next;

  slot_result_t     expected_results[$];

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  // Applies one handle operation to the shadow state and returns its result.
  function automatic slot_result_t apply_handle_op(input op_t op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [GEN_W-1:0] gen);
    slot_result_t     r;
    logic [IDX_W-1:0] slot;
    r.status = ST_BAD;
    r.index  = '0;
    r.gen    = '0;
    case (op)
      OP_CREATE: begin
        // Reuse the most recently freed slot first, then never-used ones.
        if (freed_depth > 0) begin
          freed_depth--;
          slot = freed_slots[freed_depth];
        end else if (fresh_next < SLOTS) begin
          slot = IDX_W'(fresh_next);
          fresh_next++;
        end else begin
          r.status = ST_FULL;
          return r;
        end
        slot_live[slot] = 1'b1;
        r.status = ST_OK;
        r.index  = slot;
        r.gen    = slot_gen[slot];
      end
      OP_LOOKUP, OP_DESTROY: begin
        r.index = idx;
        // An index beyond the table is rejected with a zero generation.
        if (32'(idx) >= SLOTS) begin
          return r;
        end
        r.gen   = slot_gen[idx];
        if (slot_live[idx] && slot_gen[idx] == gen) begin
          // A successful destroy retires this generation and frees the slot.
          if (op == OP_DESTROY) begin
            slot_gen[idx]  = slot_gen[idx] + 1'b1;
            slot_live[idx] = 1'b0;
            if (freed_depth < SLOTS) begin
              freed_slots[freed_depth] = idx;
              freed_depth++;
            end
          end
          r.status = ST_OK;
          r.gen    = slot_gen[idx];
        end
      end
      default: begin
        // The unused opcode is rejected with zero fields.
      end
    endcase
    return r;
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin : watch_channels
    slot_result_t want;
    int           k;
    if (rst) begin
      for (k = 0; k < SLOTS; k++) begin
        slot_gen[k]  = '0;
        slot_live[k] = 1'b0;
      end
      freed_depth = 0;
      fresh_next  = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results = {expected_results,
                            apply_handle_op(op_t'(s_tdata[1:0]), s_tdata[11:2],
                                            s_tdata[43:12])};
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", '0, m_tdata[31:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] != want.status) begin
            report_mismatch("status", want.status, m_tdata[1:0]);
          end
          if (m_tdata[11:2] != want.index) begin
            report_mismatch("out_index", want.index, m_tdata[11:2]);
          end
          if (m_tdata[43:12] != want.gen) begin
            report_mismatch("out_generation", want.gen, m_tdata[43:12]);
          end
        end
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Drives handle operations into the slot map and gives the verdict; all
// checking is done by the slot map checker beside the block.
module testbench;
  import gsm_pkg::*;

  localparam int SLOTS           = 1024;
  localparam int RANDOM_OPS      = 1800;
  localparam int PHASE_OPS       = RANDOM_OPS / 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 16;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] idx;
  } handle_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  int          mismatch_count;
  int          pending_results;
  int          items_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_output;
  int          idle_cycles;
  int          full_hits;

  // Handles known to be live, handles already destroyed, and the operation
  // of every request whose result is still on its way.
  handle_t     live_handles[$];
  handle_t     dead_handles[$];
  op_t         issued_ops[$];

  generational_slot_map #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  slot_map_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one request, with random idle cycles ahead of it, and waits until
  // the transaction is accepted.
  task automatic offer_op(input op_t op, input logic [IDX_W-1:0] idx,
                          input logic [GEN_W-1:0] gen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, gen, idx, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Lookup or destroy chosen at random.
  function automatic op_t check_op();
    return ($urandom_range(0, 1) != 0) ? OP_DESTROY : OP_LOOKUP;
  endfunction

  // Stimulus: directed handle sequences first, then weighted random traffic.
  initial begin : stimulus
    int      n;
    int      k;
    int      roll;
    int      create_pct;
    int      lookup_pct;
    int      destroy_pct;
    handle_t h;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Basic life cycle, stale handles, LIFO reuse and the unused opcode.
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_LOOKUP, 10'd0, 32'd0);
    offer_op(OP_LOOKUP, 10'd0, 32'hFFFF_FFFF);
    offer_op(OP_LOOKUP, 10'd1023, 32'd0);
    offer_op(OP_DESTROY, 10'd0, 32'd0);
    offer_op(OP_LOOKUP, 10'd0, 32'd0);
    offer_op(OP_DESTROY, 10'd0, 32'd1);
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_LOOKUP, 10'd0, 32'd1);
    offer_op(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF);
    offer_op(OP_UNUSED, 10'd0, 32'd0);
    offer_op(OP_DESTROY, 10'd1, 32'd0);
    offer_op(OP_DESTROY, 10'd0, 32'd1);
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_CREATE, 10'd0, 32'd0);
    offer_op(OP_LOOKUP, 10'd1023, 32'hFFFF_FFFF);
    offer_op(OP_DESTROY, 10'd1023, 32'd0);
    offer_op(OP_LOOKUP, 10'd2, 32'd0);

    for (n = 0; n < RANDOM_OPS; n++) begin
      // Idle pattern per phase: none, sender, receiver, both.
      case (n / PHASE_OPS)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // Fill the table first, then churn around the full boundary.
      if (full_hits < 6) begin
        create_pct = 85; lookup_pct = 6; destroy_pct = 5;
      end else begin
        create_pct = 38; lookup_pct = 24; destroy_pct = 26;
      end
      roll = $urandom_range(0, 99);
      if (roll < create_pct || (roll < create_pct + lookup_pct + destroy_pct &&
                                live_handles.size() == 0)) begin
        offer_op(OP_CREATE, 10'($urandom_range(0, 1023)), $urandom);
      end else if (roll < create_pct + lookup_pct) begin
        k = $urandom_range(0, live_handles.size() - 1);
        offer_op(OP_LOOKUP, live_handles[k].idx, live_handles[k].gen);
      end else if (roll < create_pct + lookup_pct + destroy_pct) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        live_handles.delete(k);
        dead_handles = {dead_handles, h};
        if (dead_handles.size() > 64) begin
          void'(dead_handles.pop_front());
        end
        offer_op(OP_DESTROY, h.idx, h.gen);
      end else begin
        // Malformed traffic: retired handles, wrong generations, random
        // handles and the unused opcode.
        case ($urandom_range(0, 3))
          0: begin
            if (dead_handles.size() > 0) begin
              h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
              offer_op(check_op(), h.idx, h.gen);
            end else begin
              offer_op(check_op(), 10'($urandom_range(0, 1023)), $urandom);
            end
          end
          1: offer_op(check_op(), 10'($urandom_range(0, 1023)), $urandom);
          2: offer_op(OP_UNUSED, 10'($urandom_range(0, 1023)), $urandom);
          default: begin
            if (live_handles.size() > 0) begin
              h = live_handles[$urandom_range(0, live_handles.size() - 1)];
              offer_op(check_op(), h.idx, h.gen ^ (32'd1 << $urandom_range(0, 31)));
            end else begin
              offer_op(check_op(), 10'($urandom_range(0, 1023)), $urandom);
            end
          end
        endcase
      end
    end
    s_tvalid <= 1'b0;

    // Let every result drain, then give the verdict.
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin : receiver
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= !hold_output && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : receiver_hold
    hold_output = 1'b0;
    wait (items_sent >= 200);
    @(posedge clk);
    hold_output = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_output = 1'b0;
  end

  // Track issued handles from the results so that later requests can use them.
  always @(posedge clk) begin : track_handles
    op_t     done_op;
    handle_t h;
    int      k;
    if (rst) begin
      full_hits = 0;
    end else begin
      if (m_tvalid && m_tready && issued_ops.size() > 0) begin
        done_op = issued_ops.pop_front();
        if (done_op == OP_CREATE && m_tdata[1:0] == ST_OK) begin
          h.idx = m_tdata[11:2];
          h.gen = m_tdata[43:12];
          live_handles = {live_handles, h};
        end else if (done_op == OP_CREATE && m_tdata[1:0] == ST_FULL) begin
          full_hits++;
        end else if (done_op == OP_DESTROY && m_tdata[1:0] == ST_OK) begin
          for (k = 0; k < live_handles.size(); k++) begin
            if (live_handles[k].idx == m_tdata[11:2] &&
                live_handles[k].gen == 32'(m_tdata[43:12] - 32'd1)) begin
              live_handles.delete(k);
              break;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        issued_ops = {issued_ops, op_t'(s_tdata[1:0])};
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/gsm_pkg.sv
rtl/gsm_ram.sv
rtl/gsm_seq.sv
rtl/generational_slot_map.sv
sim/slot_map_checker.sv
sim/testbench.sv
